// ===== rtl/grld_pkg.sv =====
// ----------------------------------------------------------------------------
// grld_pkg
// Shared constants and types for the Golomb run-length decoder.
// ----------------------------------------------------------------------------
package grld_pkg;

    localparam int CS_W       = 5;
    localparam int TL_W       = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int FIFO_DEPTH = 4;

    // register index, taken from the paddr word bit
    localparam logic REG_CODE_SELECT  = 1'b0;
    localparam logic REG_TOTAL_LENGTH = 1'b1;

    localparam logic [CS_W-1:0] CS_RESET = '0;
    localparam logic [TL_W-1:0] TL_RESET = TL_W'(1);

    typedef struct packed {
        logic [CS_W-1:0] code_select;
        logic [TL_W-1:0] total_length;
    } t_cfg;

endpackage

// ===== rtl/grld_in_if.sv =====
// ----------------------------------------------------------------------------
// grld_in_if
// Code bit channel: one compressed-stream bit per item.
// ----------------------------------------------------------------------------
interface grld_in_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic start_req;

    modport source (output valid, output code_bit, output start_req, input ready);
    modport sink   (input valid, input code_bit, input start_req, output ready);
endinterface

// ===== rtl/grld_out_if.sv =====
// ----------------------------------------------------------------------------
// grld_out_if
// Run channel: one decoded run length per item, with a final-run mark.
// ----------------------------------------------------------------------------
interface grld_out_if #(
    parameter int RUN_WIDTH = 24
);
    logic                 valid;
    logic                 ready;
    logic [RUN_WIDTH-1:0] run_value;
    logic                 last;

    modport source (output valid, output run_value, output last, input ready);
    modport sink   (input valid, input run_value, input last, output ready);
endinterface

// ===== rtl/grld_cfg.sv =====
// ----------------------------------------------------------------------------
// grld_cfg
// APB register file holding the codebook select and the target length.
// ----------------------------------------------------------------------------
module grld_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [grld_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [grld_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [grld_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output grld_pkg::t_cfg                      o_cfg
);

    logic [grld_pkg::CS_W-1:0] r_code_select;
    logic [grld_pkg::TL_W-1:0] r_total_length;
    logic                      w_idx;
    logic                      w_wr;

    assign w_idx  = paddr[2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_select  <= grld_pkg::CS_RESET;
            r_total_length <= grld_pkg::TL_RESET;
        end else if (w_wr) begin
            case (w_idx)
                grld_pkg::REG_CODE_SELECT: begin
                    r_code_select <= pwdata[grld_pkg::CS_W-1:0];
                end
                grld_pkg::REG_TOTAL_LENGTH: begin
                    r_total_length <= pwdata[grld_pkg::TL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            grld_pkg::REG_CODE_SELECT: begin
                prdata = grld_pkg::APB_DATA_W'(r_code_select);
            end
            grld_pkg::REG_TOTAL_LENGTH: begin
                prdata = grld_pkg::APB_DATA_W'(r_total_length);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.code_select  = r_code_select;
    assign o_cfg.total_length = r_total_length;

endmodule

// ===== rtl/grld_core.sv =====
// ----------------------------------------------------------------------------
// grld_core
// Per-bit Golomb decode step: code word state, length sum and held run.
// Emits zero, one or two runs for each accepted bit.
// ----------------------------------------------------------------------------
module grld_core #(
    parameter int RUN_WIDTH    = 24,
    parameter int MAX_REM_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_code_bit,
    input  logic                 i_start_req,
    input  grld_pkg::t_cfg       i_cfg,
    output logic [1:0]           o_push_cnt,
    output logic [RUN_WIDTH:0]   o_push_data [2]
);

    localparam int BL_W   = $clog2(MAX_REM_BITS + 1);
    localparam int WIDE_W = (RUN_WIDTH > MAX_REM_BITS + 2) ? RUN_WIDTH : MAX_REM_BITS + 2;
    localparam int QW     = WIDE_W + 1;
    localparam int VW     = WIDE_W + 2;
    localparam int SUM_W  = (RUN_WIDTH + 1 > grld_pkg::TL_W + 1) ?
                            RUN_WIDTH + 1 : grld_pkg::TL_W + 1;
    localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_UNARY,
        PH_PREFIX1,
        PH_PREFIX2,
        PH_REM,
        PH_FLAG,
        PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        OFF_NONE,
        OFF_ONE,
        OFF_TWO
    } t_off;

    t_phase                    r_phase, n_phase, s_phase;
    logic [RUN_WIDTH-1:0]      r_quot, n_quot, s_quot;
    logic [MAX_REM_BITS-1:0]   r_rem, n_rem, s_rem;
    logic [BL_W-1:0]           r_bits_left, n_bits_left, s_bits_left;
    t_off                      r_pick, n_pick, s_pick;
    logic [SUM_W-1:0]          r_sum, n_sum, s_sum;
    logic [RUN_WIDTH-1:0]      r_pend, n_pend, s_pend;
    logic                      r_pend_v, n_pend_v, s_pend_v;

    logic                      w_odd;
    logic [grld_pkg::CS_W-1:0] w_kraw;
    logic [BL_W-1:0]           w_k;
    logic [QW-1:0]             w_step;
    logic [QW-1:0]             w_qsum;
    logic [MAX_REM_BITS-1:0]   w_shifted;
    logic [BL_W-1:0]           w_bl_dec;
    t_off                      w_fpick;
    logic [MAX_REM_BITS-1:0]   w_frem;
    logic [VW-1:0]             w_off;
    logic [VW-1:0]             w_vsum;
    logic [RUN_WIDTH-1:0]      w_run;
    logic [SUM_W-1:0]          w_new_sum;
    logic                      w_fin;
    logic [1:0]                w_cnt;
    logic [RUN_WIDTH:0]        w_d0, w_d1;

    // main decoding goes on while sum + 1 stays below the target
    function automatic t_phase main_or_flag(input logic [SUM_W-1:0] sum,
                                            input logic [grld_pkg::TL_W-1:0] tl);
        logic [SUM_W:0] nxt;
        nxt = (SUM_W + 1)'(sum) + (SUM_W + 1)'(1);
        return (nxt < (SUM_W + 1)'(tl)) ? PH_UNARY : PH_FLAG;
    endfunction

    // codebook decode
    assign w_odd  = i_cfg.code_select[0];
    assign w_kraw = (grld_pkg::CS_W)'(i_cfg.code_select[grld_pkg::CS_W-1:1])
                    + (grld_pkg::CS_W)'(!w_odd);
    assign w_k    = (w_kraw > (grld_pkg::CS_W)'(MAX_REM_BITS)) ?
                    BL_W'(MAX_REM_BITS) : w_kraw[BL_W-1:0];
    assign w_step = w_odd ? (QW'(3) << w_k) : (QW'(1) << w_k);

    // a start request clears the block state ahead of this bit
    always_comb begin
        if (i_start_req) begin
            s_phase     = main_or_flag('0, i_cfg.total_length);
            s_quot      = '0;
            s_rem       = '0;
            s_bits_left = '0;
            s_pick      = OFF_NONE;
            s_sum       = '0;
            s_pend      = '0;
            s_pend_v    = 1'b0;
        end else begin
            s_phase     = r_phase;
            s_quot      = r_quot;
            s_rem       = r_rem;
            s_bits_left = r_bits_left;
            s_pick      = r_pick;
            s_sum       = r_sum;
            s_pend      = r_pend;
            s_pend_v    = r_pend_v;
        end
    end

    assign w_qsum    = QW'(s_quot) + w_step;
    assign w_shifted = (s_rem << 1) | MAX_REM_BITS'(i_code_bit);
    assign w_bl_dec  = (s_bits_left != '0) ? s_bits_left - BL_W'(1) : '0;

    // run value of a finished code word
    always_comb begin
        case (s_phase)
            PH_PREFIX1: w_fpick = OFF_NONE;
            PH_PREFIX2: w_fpick = i_code_bit ? OFF_TWO : OFF_ONE;
            default:    w_fpick = s_pick;
        endcase
        w_frem = (s_phase == PH_REM) ? w_shifted : s_rem;
        case (w_fpick)
            OFF_ONE: w_off = VW'(1) << w_k;
            OFF_TWO: w_off = VW'(2) << w_k;
            default: w_off = '0;
        endcase
    end

    assign w_vsum    = VW'(s_quot) + VW'(w_frem) + w_off + VW'(1);
    assign w_run     = (w_vsum > VW'(RUN_MAX)) ? RUN_MAX : w_vsum[RUN_WIDTH-1:0];
    assign w_new_sum = s_sum + SUM_W'(w_run) - SUM_W'(1);

    always_comb begin
        n_phase     = s_phase;
        n_quot      = s_quot;
        n_rem       = s_rem;
        n_bits_left = s_bits_left;
        n_pick      = s_pick;
        n_sum       = s_sum;
        n_pend      = s_pend;
        n_pend_v    = s_pend_v;
        w_fin       = 1'b0;
        w_cnt       = 2'd0;
        w_d0        = {s_pend, 1'b0};
        w_d1        = {RUN_WIDTH'(1), 1'b1};

        case (s_phase)
            PH_UNARY: begin
                if (i_code_bit) begin
                    n_quot = (w_qsum > QW'(RUN_MAX)) ? RUN_MAX : w_qsum[RUN_WIDTH-1:0];
                end else if (w_odd) begin
                    n_phase = PH_PREFIX1;
                end else begin
                    n_pick      = OFF_NONE;
                    n_bits_left = w_k;
                    n_rem       = '0;
                    n_phase     = PH_REM;
                end
            end
            PH_PREFIX1, PH_PREFIX2: begin
                if (s_phase == PH_PREFIX1 && i_code_bit) begin
                    n_phase = PH_PREFIX2;
                end else begin
                    n_pick = w_fpick;
                    if (w_k == '0) begin
                        w_fin = 1'b1;
                    end else begin
                        n_bits_left = w_k;
                        n_rem       = '0;
                        n_phase     = PH_REM;
                    end
                end
            end
            PH_REM: begin
                n_rem       = w_shifted;
                n_bits_left = w_bl_dec;
                w_fin       = (w_bl_dec == '0);
            end
            PH_FLAG: begin
                if (i_code_bit) begin
                    n_phase = PH_TAIL;
                end else begin
                    // held run closes the block
                    w_d0     = {s_pend, 1'b1};
                    w_cnt    = s_pend_v ? 2'd1 : 2'd0;
                    n_pend_v = 1'b0;
                    n_phase  = PH_IDLE;
                end
            end
            PH_TAIL: begin
                if (i_code_bit) begin
                    w_cnt    = s_pend_v ? 2'd1 : 2'd0;
                    n_pend   = RUN_WIDTH'(1);
                    n_pend_v = 1'b1;
                end else begin
                    if (s_pend_v) begin
                        w_cnt = 2'd2;
                    end else begin
                        w_d0  = {RUN_WIDTH'(1), 1'b1};
                        w_cnt = 2'd1;
                    end
                    n_pend_v = 1'b0;
                    n_phase  = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (w_fin) begin
            // release the held run, hold the new one
            w_cnt       = s_pend_v ? 2'd1 : 2'd0;
            n_pend      = w_run;
            n_pend_v    = 1'b1;
            n_sum       = w_new_sum;
            n_quot      = '0;
            n_rem       = '0;
            n_bits_left = '0;
            n_pick      = OFF_NONE;
            n_phase     = main_or_flag(w_new_sum, i_cfg.total_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_quot      <= '0;
            r_rem       <= '0;
            r_bits_left <= '0;
            r_pick      <= OFF_NONE;
            r_sum       <= '0;
            r_pend      <= '0;
            r_pend_v    <= 1'b0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_quot      <= n_quot;
            r_rem       <= n_rem;
            r_bits_left <= n_bits_left;
            r_pick      <= n_pick;
            r_sum       <= n_sum;
            r_pend      <= n_pend;
            r_pend_v    <= n_pend_v;
        end
    end

    assign o_push_cnt     = i_take ? w_cnt : 2'd0;
    assign o_push_data[0] = w_d0;
    assign o_push_data[1] = w_d1;

endmodule

// ===== rtl/grld_ofifo.sv =====
// ----------------------------------------------------------------------------
// grld_ofifo
// Small result queue: takes up to two items per cycle, releases one.
// ----------------------------------------------------------------------------
module grld_ofifo #(
    parameter int W = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  logic [W-1:0]  i_push_data [2],
    input  logic          i_pop,
    output logic          o_room,
    output logic          o_valid,
    output logic [W-1:0]  o_data
);

    localparam int DEPTH = grld_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] w_wr1;
    logic          w_pop;

    assign w_wr1   = r_wr + PW'(1);
    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    // keep room for the two items a single bit can cause
    assign o_room  = (r_cnt <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push_data[0];
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push_data[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PW'(i_push_cnt);
            r_rd  <= r_rd + PW'(w_pop);
            r_cnt <= r_cnt + CW'(i_push_cnt) - CW'(w_pop);
        end
    end

endmodule

// ===== rtl/golomb_run_length_decoder.sv =====
// ----------------------------------------------------------------------------
// golomb_run_length_decoder
// Decodes Golomb / Golomb-Rice run lengths from a bit stream, one code bit
// per item and one item per clock. Each bit goes through a single decode
// step between the state registers and a four-entry result queue; the queue
// absorbs the two runs a closing tail bit can produce, so input is taken
// every cycle while the queue holds at most two results, and results leave
// one per cycle while o_runs.ready is high. A run appears on the output one
// code word late so that the final run of a block carries the last mark.
// Program code_select and total_length over APB while the decoder is idle;
// start_req on a bit begins a new block with that bit.
// ----------------------------------------------------------------------------
module golomb_run_length_decoder #(
    parameter int RUN_WIDTH    = 24,
    parameter int MAX_REM_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    grld_in_if.sink                          i_bits,
    grld_out_if.source                       o_runs,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [grld_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [grld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [grld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    grld_pkg::t_cfg     w_cfg;
    logic               w_take;
    logic               w_room;
    logic [1:0]         w_push_cnt;
    logic [RUN_WIDTH:0] w_push_data [2];
    logic [RUN_WIDTH:0] w_head;

    grld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_bits.ready = w_room;
    assign w_take       = i_bits.valid && w_room;

    grld_core #(
        .RUN_WIDTH    (RUN_WIDTH),
        .MAX_REM_BITS (MAX_REM_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_code_bit  (i_bits.code_bit),
        .i_start_req (i_bits.start_req),
        .i_cfg       (w_cfg),
        .o_push_cnt  (w_push_cnt),
        .o_push_data (w_push_data)
    );

    grld_ofifo #(
        .W (RUN_WIDTH + 1)
    ) u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_push_data (w_push_data),
        .i_pop       (o_runs.ready),
        .o_room      (w_room),
        .o_valid     (o_runs.valid),
        .o_data      (w_head)
    );

    assign o_runs.run_value = w_head[RUN_WIDTH:1];
    assign o_runs.last      = w_head[0];

endmodule
